// ----- hdl/int16_matrix_multiply_defines.svh -----
// Assertion macros included by int16_matrix_multiply, the file that carries concurrent checks.
`ifndef INT16_MATRIX_MULTIPLY_DEFINES_SVH
`define INT16_MATRIX_MULTIPLY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/imm_pkg.sv -----
package imm_pkg;

   localparam int IMM_MODE_W  = 2;
   localparam int IMM_IDX_W   = 6;
   localparam int IMM_DATA_W  = 16;
   localparam int IMM_LEN_W   = 7;
   localparam int IMM_ADDR_W  = 3;
   localparam int IMM_CSR_W   = 32;

   localparam logic [IMM_MODE_W-1:0] MODE_WRITE_LEFT  = 2'd0;
   localparam logic [IMM_MODE_W-1:0] MODE_WRITE_RIGHT = 2'd1;
   localparam logic [IMM_MODE_W-1:0] MODE_REQUEST     = 2'd2;

   // Register index is taken from byte address bit 2.
   localparam logic REG_INNER_LENGTH = 1'b0;
   localparam logic [IMM_LEN_W-1:0] INNER_LENGTH_RESET = 7'd64;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RUN    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   typedef struct packed {
      logic wr_left;
      logic wr_right;
      logic rd_en;
   } mem_ctl_type;

   typedef struct packed {
      logic clear;
      logic term_valid;
   } mac_ctl_type;

endpackage

// ----- hdl/imm_stream_if.sv -----
interface imm_req_if;
   logic                                    valid;
   logic                                    ready;
   logic        [imm_pkg::IMM_MODE_W-1:0]   mode;
   logic        [imm_pkg::IMM_IDX_W-1:0]    row_index;
   logic        [imm_pkg::IMM_IDX_W-1:0]    col_index;
   logic signed [imm_pkg::IMM_DATA_W-1:0]   element_value;

   modport source (output valid, mode, row_index, col_index, element_value, input ready);
   modport sink   (input valid, mode, row_index, col_index, element_value, output ready);
endinterface

interface imm_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [imm_pkg::IMM_DATA_W-1:0]   product_value;
   logic        [imm_pkg::IMM_IDX_W-1:0]    out_row;
   logic        [imm_pkg::IMM_IDX_W-1:0]    out_col;

   modport source (output valid, product_value, out_row, out_col, input ready);
   modport sink   (input valid, product_value, out_row, out_col, output ready);
endinterface

// ----- hdl/imm_csr.sv -----
module imm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [imm_pkg::IMM_ADDR_W-1:0]   csr_paddr,
   input  logic [imm_pkg::IMM_CSR_W-1:0]    csr_pwdata,
   output logic [imm_pkg::IMM_CSR_W-1:0]    csr_prdata,
   output logic                             csr_pready,
   output logic [imm_pkg::IMM_LEN_W-1:0]    inner_length
);
   import imm_pkg::*;

   logic [IMM_LEN_W-1:0] inner_length_ff;
   logic [IMM_LEN_W-1:0] inner_length_in;
   logic                 wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_INNER_LENGTH);

   always_comb begin
      inner_length_in = inner_length_ff;
      if (wr_hit) begin
         inner_length_in = csr_pwdata[IMM_LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_length_ff <= INNER_LENGTH_RESET;
      end else begin
         inner_length_ff <= inner_length_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_INNER_LENGTH) begin
         csr_prdata = {{(IMM_CSR_W-IMM_LEN_W){1'b0}}, inner_length_ff};
      end
   end

   assign inner_length = inner_length_ff;
endmodule

// ----- hdl/imm_store.sv -----
module imm_store #(
   parameter int AW = 12
) (
   input  logic                             clock,
   input  imm_pkg::mem_ctl_type             mem_ctl,
   input  logic [AW-1:0]                    wr_addr,
   input  logic [imm_pkg::IMM_DATA_W-1:0]   wr_data,
   input  logic [AW-1:0]                    rd_addr_left,
   input  logic [AW-1:0]                    rd_addr_right,
   output logic [imm_pkg::IMM_DATA_W-1:0]   rd_left,
   output logic [imm_pkg::IMM_DATA_W-1:0]   rd_right
);
   import imm_pkg::*;

   localparam int DEPTH = 2 ** AW;

   logic [IMM_DATA_W-1:0] left_mem  [DEPTH];
   logic [IMM_DATA_W-1:0] right_mem [DEPTH];
   logic [IMM_DATA_W-1:0] rd_left_ff;
   logic [IMM_DATA_W-1:0] rd_right_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_left) begin
         left_mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_left_ff <= left_mem[rd_addr_left];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_right) begin
         right_mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_right_ff <= right_mem[rd_addr_right];
      end
   end

   assign rd_left  = rd_left_ff;
   assign rd_right = rd_right_ff;
endmodule

// ----- hdl/imm_mac.sv -----
module imm_mac (
   input  logic                             clock,
   input  logic                             reset,
   input  imm_pkg::mac_ctl_type             mac_ctl,
   input  logic [imm_pkg::IMM_DATA_W-1:0]   left_data,
   input  logic [imm_pkg::IMM_DATA_W-1:0]   right_data,
   output logic                             busy,
   output logic [imm_pkg::IMM_DATA_W-1:0]   acc
);
   import imm_pkg::*;

   logic [2*IMM_DATA_W-1:0] full_prod;
   logic [IMM_DATA_W-1:0]   prod_ff;
   logic [IMM_DATA_W-1:0]   prod_in;
   logic                    prod_valid_ff;
   logic [IMM_DATA_W-1:0]   acc_ff;
   logic [IMM_DATA_W-1:0]   acc_in;

   // Only the low half of the product survives the 16-bit wrap, so the
   // signedness of the operands does not matter here.
   assign full_prod = left_data * right_data;
   assign prod_in   = mac_ctl.term_valid ? full_prod[IMM_DATA_W-1:0] : '0;

   always_comb begin
      acc_in = acc_ff;
      if (mac_ctl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= mac_ctl.term_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign busy = prod_valid_ff;
   assign acc  = acc_ff;
endmodule

// ----- hdl/int16_matrix_multiply.sv -----
// Signed 16-bit matrix product engine.
// Items arrive on the req_chan channel (valid/ready). Mode write-left and
// write-right store element_value into matrix A or B at row_index, col_index;
// they give no result and leave the block idle. A request item walks the inner
// dimension, reading A[row][k] and B[k][col] from two separate memories,
// one pair per cycle, and returns C[row][col] wrapped to 16 bits on rsp_chan
// together with its row and column. Mode three is dropped.
// A request keeps req_chan.ready low until its result is loaded into the
// output register: the memory read, the registered multiply and the accumulate
// form a short pipeline behind a single address counter, so one term enters
// per cycle. The result becomes valid in the same cycle as req_chan.ready
// rises again for the next item.
// The result sits in an output register; if the receiver stalls, the block
// still accepts writes and starts the next request, and only that request's
// final hand-off waits for the register to empty.
// inner_length is set through the csr_ APB port at byte address 0 and must
// only change while the block is idle. Reset clears the control state and
// sets inner_length to 64; the matrix memories keep no reset value and must
// be written before they are read.
module int16_matrix_multiply #(
   parameter int MAX_DIM = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   imm_req_if.sink                           req_chan,
   imm_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [imm_pkg::IMM_ADDR_W-1:0]    csr_paddr,
   input  logic [imm_pkg::IMM_CSR_W-1:0]     csr_pwdata,
   output logic [imm_pkg::IMM_CSR_W-1:0]     csr_prdata,
   output logic                              csr_pready
);
   import imm_pkg::*;

   `include "int16_matrix_multiply_defines.svh"

   // Index width of one matrix dimension, and a width wide enough for both
   // that index and the counter over the inner dimension.
   localparam int IW = $clog2(MAX_DIM);
   localparam int AW = 2 * IW;
   localparam int EW = (IW > IMM_LEN_W) ? IW : IMM_LEN_W;
   localparam int CW = 10;

   state_type state_ff, state_in;

   logic [IMM_LEN_W-1:0]  inner_length;
   logic [IMM_LEN_W-1:0]  len_sat;
   logic [IMM_LEN_W-1:0]  len_ff, len_in;
   logic [IMM_LEN_W-1:0]  k_ff, k_in;
   logic [IMM_IDX_W-1:0]  row_ff, row_in;
   logic [IMM_IDX_W-1:0]  col_ff, col_in;
   logic                  in_range_ff, in_range_in;
   logic                  rd_valid_ff;

   logic                  accept;
   logic                  start;
   logic                  issue;
   logic                  load_rsp;
   logic                  row_ok;
   logic                  col_ok;

   logic [EW-1:0]         row_ext;
   logic [EW-1:0]         col_ext;
   logic [EW-1:0]         k_ext;
   logic [EW-1:0]         req_row_ext;
   logic [EW-1:0]         req_col_ext;

   mem_ctl_type           mem_ctl;
   mac_ctl_type           mac_ctl;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr_left;
   logic [AW-1:0]         rd_addr_right;
   logic [IMM_DATA_W-1:0] rd_left;
   logic [IMM_DATA_W-1:0] rd_right;
   logic                  mac_busy;
   logic [IMM_DATA_W-1:0] acc;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IMM_DATA_W-1:0] rsp_value_ff;
   logic [IMM_IDX_W-1:0]  rsp_row_ff;
   logic [IMM_IDX_W-1:0]  rsp_col_ff;

   imm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .inner_length (inner_length)
   );

   // A length above the store dimension is clamped to the dimension.
   assign len_sat = ({{(CW-IMM_LEN_W){1'b0}}, inner_length} > CW'(MAX_DIM))
                    ? IMM_LEN_W'(MAX_DIM) : inner_length;

   // Indices of the incoming item; those that fall outside the stores make
   // a write a no-op and a request sum to zero.
   assign row_ok = {{(CW-IMM_IDX_W){1'b0}}, req_chan.row_index} < CW'(MAX_DIM);
   assign col_ok = {{(CW-IMM_IDX_W){1'b0}}, req_chan.col_index} < CW'(MAX_DIM);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign start  = accept && (req_chan.mode == MODE_REQUEST);

   // Writes happen only in the idle state and reads only while running, so
   // the two never touch the same entry in one cycle.
   assign req_row_ext = EW'(req_chan.row_index);
   assign req_col_ext = EW'(req_chan.col_index);
   assign wr_addr     = {req_row_ext[IW-1:0], req_col_ext[IW-1:0]};

   assign issue = (state_ff == ST_RUN) && (k_ff != len_ff);

   assign row_ext       = EW'(row_ff);
   assign col_ext       = EW'(col_ff);
   assign k_ext         = EW'(k_ff);
   assign rd_addr_left  = {row_ext[IW-1:0], k_ext[IW-1:0]};
   assign rd_addr_right = {k_ext[IW-1:0], col_ext[IW-1:0]};

   always_comb begin
      mem_ctl.wr_left  = accept && row_ok && col_ok && (req_chan.mode == MODE_WRITE_LEFT);
      mem_ctl.wr_right = accept && row_ok && col_ok && (req_chan.mode == MODE_WRITE_RIGHT);
      mem_ctl.rd_en    = issue;
   end

   imm_store #(
      .AW (AW)
   ) u_store (
      .clock         (clock),
      .mem_ctl       (mem_ctl),
      .wr_addr       (wr_addr),
      .wr_data       (req_chan.element_value),
      .rd_addr_left  (rd_addr_left),
      .rd_addr_right (rd_addr_right),
      .rd_left       (rd_left),
      .rd_right      (rd_right)
   );

   always_comb begin
      mac_ctl.clear      = start;
      mac_ctl.term_valid = rd_valid_ff && in_range_ff;
   end

   imm_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .mac_ctl    (mac_ctl),
      .left_data  (rd_left),
      .right_data (rd_right),
      .busy       (mac_busy),
      .acc        (acc)
   );

   // The sum is final once the counter has run out and the read and
   // multiply stages have drained into the accumulator.
   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      len_in      = len_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      in_range_in = in_range_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in    = ST_RUN;
               k_in        = '0;
               len_in      = len_sat;
               row_in      = req_chan.row_index;
               col_in      = req_chan.col_index;
               in_range_in = row_ok && col_ok;
            end
         end
         ST_RUN: begin
            if (issue) begin
               k_in = k_ff + 1'b1;
            end else if (!rd_valid_ff && !mac_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rd_valid_ff  <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      in_range_ff <= in_range_in;
      if (load_rsp) begin
         rsp_value_ff <= acc;
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= col_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.product_value = rsp_value_ff;
   assign rsp_chan.out_row       = rsp_row_ff;
   assign rsp_chan.out_col       = rsp_col_ff;

   // A running request must never take in another item.
   `IMM_ASSERT_SAME(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_chan.ready, "item taken while busy")
   // A memory write and a memory read never share a cycle.
   `IMM_ASSERT_SAME(a_no_rw_overlap, clock, reset, mem_ctl.wr_left || mem_ctl.wr_right, !mem_ctl.rd_en, "memory write during read")
   // The inner counter never runs past the latched length.
   `IMM_ASSERT_SAME(a_k_bound, clock, reset, state_ff == ST_RUN, k_ff <= len_ff, "inner counter overran")
   // A request that is taken starts the walk in the next cycle.
   `IMM_ASSERT_NEXT(a_start_runs, clock, reset, start, state_ff == ST_RUN && k_ff == '0, "request did not start")
endmodule
